// ===== hdl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// deq_pkg
// Types, constants and slot arithmetic shared by the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes carried on kind_i
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } state_e;

  // Write request to the entry store
  typedef struct packed {
    logic  en;
    idx_t  addr;
    data_t data;
  } wr_req_t;

  // Slot that lies off places behind base, wrapped round the store
  function automatic idx_t wrap_slot(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/deq_ram.sv =====
// ---------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port with a registered read word.
// ---------------------------------------------------------------------------
module deq_ram
  import deq_pkg::*;
(
  input  logic    clk_i,
  input  wr_req_t wr_i,
  input  idx_t    rd_addr_i,
  output data_t   rd_data_o
);

  data_t mem [DEPTH];
  data_t rd_data_q;

  // Write the requested entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words held in a circular store.
// ---------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low; kind_i selects
//   push front, push rear, pop front, pop rear or dump, value_i is the word
//   to push. Results appear on data_o/status_o/last_o for exactly one cycle
//   with done_o high; the receiver cannot hold them off.
// Timing:
//   Push: result in the cycle after the command, busy stays low, so a new
//   command may follow in the next cycle. Pop: the store read is
//   registered, the word is shown in the cycle after the command while
//   busy is high. Dump: one word per cycle from front to rear, the last
//   one marked, then idle. Empty pops and dumps answer in the cycle after
//   the command. The single read port of the store sets this timing.
// Reset:
//   Clears head and count; store contents are left as they are and are
//   never read before being written. Undefined kind codes give no result.
// ---------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  data_t       value_i,
  output logic        done_o,
  output data_t       data_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  state_e  state_q, state_d;
  idx_t    head_q, head_d;
  cnt_t    count_q, count_d;
  cnt_t    off_q, off_d;
  logic    done_q, done_d;
  status_e status_q, status_d;
  data_t   data_q, data_d;

  wr_req_t wr_req;
  idx_t    rd_addr;
  data_t   rd_data;
  logic    is_full, is_empty, dump_last, from_store;

  deq_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign dump_last = (off_q == count_q - cnt_t'(1));

  // Hold control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
  end

  // Decode commands, advance pointers and step the dump
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    off_d    = off_q;
    done_d   = 1'b0;
    status_d = status_q;
    data_d   = data_q;
    wr_req   = '0;
    rd_addr  = head_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (kind_e'(kind_i))
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
              done_d = 1'b1;
              data_d = value_i;
              if (is_full) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_OK;
                count_d  = count_q + cnt_t'(1);
                wr_req.en   = 1'b1;
                wr_req.data = value_i;
                if (kind_e'(kind_i) == KIND_PUSH_FRONT) begin
                  head_d = (head_q == '0) ? idx_t'(DEPTH - 1) : head_q - idx_t'(1);
                  wr_req.addr = head_d;
                end else begin
                  wr_req.addr = wrap_slot(head_q, count_q);
                end
              end
            end
            KIND_POP_FRONT, KIND_POP_REAR, KIND_DUMP: begin
              if (is_empty) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
                data_d   = '0;
              end else if (kind_e'(kind_i) == KIND_POP_FRONT) begin
                rd_addr = head_q;
                head_d  = wrap_slot(head_q, cnt_t'(1));
                count_d = count_q - cnt_t'(1);
                state_d = ST_POP;
              end else if (kind_e'(kind_i) == KIND_POP_REAR) begin
                rd_addr = wrap_slot(head_q, count_q - cnt_t'(1));
                count_d = count_q - cnt_t'(1);
                state_d = ST_POP;
              end else begin
                rd_addr = head_q;
                off_d   = '0;
                state_d = ST_DUMP;
              end
            end
            default: begin
              // undefined code: drop the command
            end
          endcase
        end
      end
      ST_POP: begin
        state_d = ST_IDLE;
      end
      ST_DUMP: begin
        if (dump_last) begin
          state_d = ST_IDLE;
        end else begin
          off_d   = off_q + cnt_t'(1);
          rd_addr = wrap_slot(head_q, off_q + cnt_t'(1));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Show store words during pop and dump, registered results otherwise
  assign from_store = (state_q == ST_POP) || (state_q == ST_DUMP);
  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q | from_store;
  assign data_o     = from_store ? rd_data : data_q;
  assign status_o   = from_store ? STAT_OK : status_q;
  assign last_o     = (state_q == ST_DUMP) ? dump_last : 1'b1;

endmodule

// ===== hdl/deq_checker.sv =====
// ---------------------------------------------------------------------------
// deq_checker
// Port-level checks on command and result timing of the queue.
// ---------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] kind_i,
  input data_t      value_i,
  input logic       done_o,
  input data_t      data_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  // Every valid command answers in the following cycle
  a_answer_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KIND_PUSH_FRONT || kind_i == KIND_PUSH_REAR ||
      kind_i == KIND_POP_FRONT || kind_i == KIND_POP_REAR || kind_i == KIND_DUMP)
    |=> done_o)
    else $error("no result after accepted command");

  // Pushes answer once, echoing the word, never with empty status
  a_push_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KIND_PUSH_FRONT || kind_i == KIND_PUSH_REAR)
    |=> last_o && data_o == $past(value_i) && status_o != STAT_EMPTY)
    else $error("push result malformed");

  // Undefined codes produce no word
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !(kind_i == KIND_PUSH_FRONT || kind_i == KIND_PUSH_REAR ||
      kind_i == KIND_POP_FRONT || kind_i == KIND_POP_REAR || kind_i == KIND_DUMP)
    |=> !done_o)
    else $error("result for undefined command");

  // An unfinished dump keeps the block busy
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy && status_o == STAT_OK)
    else $error("dump word while idle");

  // Empty status closes the answer with a zero word
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STAT_EMPTY |-> last_o && data_o == '0)
    else $error("empty result malformed");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .kind_i   (kind_i),
  .value_i  (value_i),
  .done_o   (done_o),
  .data_o   (data_o),
  .status_o (status_o),
  .last_o   (last_o)
);
